### sv/ofp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ofp_pkg
// Types and constants shared by the optical-flow frame parser modules.
// ----------------------------------------------------------------------------
package ofp_pkg;

   localparam int DecodeBytes = 10;
   localparam int AddrWidth   = 4;
   localparam int DataWidth   = 32;

   localparam logic [7:0] HeaderReset  = 8'd254;
   localparam logic [4:0] LengthReset  = 5'd10;
   localparam logic [7:0] FooterReset  = 8'd85;
   localparam logic [7:0] MarkerReset  = 8'd245;

   localparam logic [1:0] REG_HEADER  = 2'd0;
   localparam logic [1:0] REG_LENGTH  = 2'd1;
   localparam logic [1:0] REG_FOOTER  = 2'd2;
   localparam logic [1:0] REG_MARKER  = 2'd3;

   localparam logic [1:0] ST_GOOD     = 2'd0;
   localparam logic [1:0] ST_LENGTH   = 2'd1;
   localparam logic [1:0] ST_CHECKSUM = 2'd2;
   localparam logic [1:0] ST_FOOTER   = 2'd3;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_LENGTH,
      PH_PAYLOAD,
      PH_CHECK,
      PH_FOOTER
   } phase_type;

   typedef struct packed {
      logic [7:0] header_byte;
      logic [4:0] payload_length;
      logic [7:0] footer_byte;
      logic [7:0] valid_marker;
   } cfg_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [15:0] flow_x;
      logic signed [15:0] flow_y;
      logic [15:0]        integ_span;
      logic [15:0]        distance;
      logic               measurement_valid;
      logic [7:0]         confidence;
      logic [31:0]        good_frames;
      logic [31:0]        bad_frames;
   } res_type;

endpackage
`default_nettype wire

### sv/ofp_csr.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ofp_csr
// APB register file holding the frame format settings.
// ----------------------------------------------------------------------------
module ofp_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [ofp_pkg::AddrWidth-1:0] paddr,
   input  wire logic [ofp_pkg::DataWidth-1:0] pwdata,
   output logic      [ofp_pkg::DataWidth-1:0] prdata,
   output logic                               pready,
   output ofp_pkg::cfg_type                   cfg
);
   import ofp_pkg::*;

   cfg_type    cfg_ff;
   logic [1:0] reg_index;
   logic       write_en;

   assign pready    = 1'b1;
   assign reg_index = paddr[3:2];
   assign write_en  = psel & penable & pwrite & pready;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_byte    <= HeaderReset;
         cfg_ff.payload_length <= LengthReset;
         cfg_ff.footer_byte    <= FooterReset;
         cfg_ff.valid_marker   <= MarkerReset;
      end else if (write_en) begin
         case (reg_index)
            REG_HEADER: cfg_ff.header_byte    <= pwdata[7:0];
            REG_LENGTH: cfg_ff.payload_length <= pwdata[4:0];
            REG_FOOTER: cfg_ff.footer_byte    <= pwdata[7:0];
            REG_MARKER: cfg_ff.valid_marker   <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_HEADER: prdata = {24'd0, cfg_ff.header_byte};
         REG_LENGTH: prdata = {27'd0, cfg_ff.payload_length};
         REG_FOOTER: prdata = {24'd0, cfg_ff.footer_byte};
         REG_MARKER: prdata = {24'd0, cfg_ff.valid_marker};
         default:    prdata = '0;
      endcase
   end

endmodule
`default_nettype wire

### sv/ofp_deframer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ofp_deframer
// Per-byte frame state machine, checksum, payload capture and counters.
// ----------------------------------------------------------------------------
module ofp_deframer (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire logic [7:0]       rx_byte,
   input  wire ofp_pkg::cfg_type cfg,
   output logic                  res_valid,
   output ofp_pkg::res_type      res
);
   import ofp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [4:0]  index_ff, index_in, index_plus;
   logic [7:0]  xor_ff, xor_in;
   logic [31:0] good_ff, good_in;
   logic [31:0] bad_ff, bad_in;
   logic [7:0]  store_ff [DecodeBytes];

   logic        length_ok, check_ok;
   logic        end_good, end_bad;
   logic [1:0]  status;
   logic        store_en;

   assign index_plus = index_ff + 5'd1;
   assign length_ok  = ({3'd0, cfg.payload_length} == rx_byte);
   assign check_ok   = (xor_ff == rx_byte);

   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_HEADER: begin
            if (rx_byte == cfg.header_byte) phase_in = PH_LENGTH;
         end
         PH_LENGTH: begin
            if (!length_ok) phase_in = PH_HEADER;
            else if (cfg.payload_length == 5'd0) phase_in = PH_CHECK;
            else phase_in = PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            if (index_plus >= cfg.payload_length) phase_in = PH_CHECK;
         end
         PH_CHECK: begin
            phase_in = check_ok ? PH_FOOTER : PH_HEADER;
         end
         PH_FOOTER: phase_in = PH_HEADER;
         default:   phase_in = PH_HEADER;
      endcase
   end

   always_comb begin
      end_good = 1'b0;
      end_bad  = 1'b0;
      status   = ST_GOOD;
      store_en = 1'b0;
      index_in = index_ff;
      xor_in   = xor_ff;
      case (phase_ff)
         PH_LENGTH: begin
            if (length_ok) begin
               index_in = 5'd0;
               xor_in   = 8'd0;
            end else begin
               end_bad = 1'b1;
               status  = ST_LENGTH;
            end
         end
         PH_PAYLOAD: begin
            store_en = 1'b1;
            index_in = index_plus;
            xor_in   = xor_ff ^ rx_byte;
         end
         PH_CHECK: begin
            if (!check_ok) begin
               end_bad = 1'b1;
               status  = ST_CHECKSUM;
            end
         end
         PH_FOOTER: begin
            if (rx_byte == cfg.footer_byte) begin
               end_good = 1'b1;
            end else begin
               end_bad = 1'b1;
               status  = ST_FOOTER;
            end
         end
         default: ;
      endcase
   end

   assign good_in = end_good ? good_ff + 32'd1 : good_ff;
   assign bad_in  = end_bad ? bad_ff + 32'd1 : bad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         index_ff <= '0;
         xor_ff   <= '0;
         good_ff  <= '0;
         bad_ff   <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         index_ff <= index_in;
         xor_ff   <= xor_in;
         good_ff  <= good_in;
         bad_ff   <= bad_in;
      end
   end

   for (genvar k = 0; k < DecodeBytes; k++) begin : g_store
      always_ff @(posedge clock) begin
         if (accept && store_en && index_ff == 5'(k)) store_ff[k] <= rx_byte;
      end
   end

   assign res_valid = end_good | end_bad;

   always_comb begin
      res                   = '0;
      res.status            = status;
      res.good_frames       = good_in;
      res.bad_frames        = bad_in;
      if (end_good) begin
         res.flow_x            = {store_ff[1], store_ff[0]};
         res.flow_y            = {store_ff[3], store_ff[2]};
         res.integ_span        = {store_ff[5], store_ff[4]};
         res.distance          = {store_ff[7], store_ff[6]};
         res.measurement_valid = (store_ff[8] == cfg.valid_marker);
         res.confidence        = store_ff[9];
      end
   end

endmodule
`default_nettype wire

### sv/ofp_result_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ofp_result_reg
// Output register for result items, held while the receiver stalls.
// ----------------------------------------------------------------------------
module ofp_result_reg (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire logic             res_valid,
   input  wire ofp_pkg::res_type res,
   input  wire logic             rsp_stall,
   output logic                  rsp_valid,
   output logic                  busy,
   output ofp_pkg::res_type      rsp
);
   import ofp_pkg::*;

   logic    valid_ff;
   res_type data_ff;
   logic    load;

   assign busy      = valid_ff & rsp_stall;
   assign load      = accept & res_valid;
   assign rsp_valid = valid_ff;
   assign rsp       = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!busy) begin
         valid_ff <= load;
      end
   end

   always_ff @(posedge clock) begin
      if (load) data_ff <= res;
   end

endmodule
`default_nettype wire

### sv/optical_flow_frame_parser_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// optical_flow_frame_parser_unit
// Deframes optical-flow sensor frames arriving one serial byte at a time.
//
// Input channel req_: one received byte per item, valid/stall handshake.
// Result channel rsp_: one item per frame that ends, carrying a status, the
// decoded little-endian fields for a good frame (zero otherwise) and the
// wrapping good and bad frame counters after that frame.
// Bytes that do not match the header while hunting are dropped.
// Throughput: one byte per cycle while req_stall is low.
// The result item is registered and appears in the cycle after the byte that ends its frame.
// The result register holds its item while rsp_stall is high; req_stall is
// raised only while that register is full and stalled.
// Reset clears the parser to header hunt, zeroes the counters and loads the
// default frame format; the payload capture registers are left as they are.
// Format registers are written through the APB port at 4-byte spacing.
// ----------------------------------------------------------------------------
module optical_flow_frame_parser_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [7:0]                    req_rx_byte,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [1:0]                         rsp_status,
   output logic signed [15:0]                 rsp_flow_x,
   output logic signed [15:0]                 rsp_flow_y,
   output logic [15:0]                        rsp_integ_span,
   output logic [15:0]                        rsp_distance,
   output logic                               rsp_measurement_valid,
   output logic [7:0]                         rsp_confidence,
   output logic [31:0]                        rsp_good_frames,
   output logic [31:0]                        rsp_bad_frames,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [ofp_pkg::AddrWidth-1:0] paddr,
   input  wire logic [ofp_pkg::DataWidth-1:0] pwdata,
   output logic      [ofp_pkg::DataWidth-1:0] prdata,
   output logic                               pready
);
   import ofp_pkg::*;

   cfg_type cfg;
   res_type res, rsp;
   logic    res_valid;
   logic    accept;

   assign accept = req_valid & ~req_stall;

   ofp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ofp_deframer u_deframer (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rx_byte   (req_rx_byte),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res)
   );

   ofp_result_reg u_result (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .res_valid (res_valid),
      .res       (res),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .busy      (req_stall),
      .rsp       (rsp)
   );

   assign rsp_status            = rsp.status;
   assign rsp_flow_x            = rsp.flow_x;
   assign rsp_flow_y            = rsp.flow_y;
   assign rsp_integ_span        = rsp.integ_span;
   assign rsp_distance          = rsp.distance;
   assign rsp_measurement_valid = rsp.measurement_valid;
   assign rsp_confidence        = rsp.confidence;
   assign rsp_good_frames       = rsp.good_frames;
   assign rsp_bad_frames        = rsp.bad_frames;

endmodule
`default_nettype wire

### sv/ofp_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ofp_checker
// Port-level checks on the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module ofp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [1:0]  rsp_status,
   input wire logic [15:0] rsp_flow_x,
   input wire logic [15:0] rsp_flow_y,
   input wire logic [15:0] rsp_integ_span,
   input wire logic [15:0] rsp_distance,
   input wire logic        rsp_measurement_valid,
   input wire logic [7:0]  rsp_confidence,
   input wire logic [31:0] rsp_bad_frames
);
   import ofp_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_bad_frames))
      else $error("stalled result item changed");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while result stalled");

   a_error_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_GOOD |-> rsp_flow_x == 16'd0
         && rsp_flow_y == 16'd0 && rsp_integ_span == 16'd0
         && rsp_distance == 16'd0 && !rsp_measurement_valid
         && rsp_confidence == 8'd0)
      else $error("error frame carries decoded fields");

endmodule

bind optical_flow_frame_parser_unit ofp_checker u_ofp_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_stall             (req_stall),
   .rsp_valid             (rsp_valid),
   .rsp_stall             (rsp_stall),
   .rsp_status            (rsp_status),
   .rsp_flow_x            (rsp_flow_x),
   .rsp_flow_y            (rsp_flow_y),
   .rsp_integ_span        (rsp_integ_span),
   .rsp_distance          (rsp_distance),
   .rsp_measurement_valid (rsp_measurement_valid),
   .rsp_confidence        (rsp_confidence),
   .rsp_bad_frames        (rsp_bad_frames)
);
`default_nettype wire
